@@ rtl/arp_icmp_reply_classifier_core_macros.svh @@
// ----------------------------------------------------------------------------
// ARP / ICMP reply classifier assertion macros
// Same-cycle and next-cycle implication checks, compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ARP_ICMP_REPLY_CLASSIFIER_CORE_MACROS_SVH
`define ARP_ICMP_REPLY_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTH
`define AIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aic assertion failed");
`define AIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aic assertion failed");
`else
`define AIC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/aic_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP / ICMP reply classifier package
// Shared constants, result codes and the frame summary passed between stages.
// ----------------------------------------------------------------------------
package aic_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 2047;
	localparam int unsigned LEN_W = 11;

	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
	localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
	localparam logic [7:0]  ICMP_ECHO_REPLY = 8'h00;

	// byte offsets within the frame
	localparam int unsigned POS_ETYPE_HI = 12;
	localparam int unsigned POS_ETYPE_LO = 13;
	localparam int unsigned POS_IHL = 14;
	localparam int unsigned POS_OPCODE_HI = 20;
	localparam int unsigned POS_OPCODE_LO = 21;
	localparam int unsigned POS_SMAC_FIRST = 22;
	localparam int unsigned POS_SMAC_LAST = 27;
	localparam int unsigned POS_IP_PROTO = 23;
	localparam int unsigned ETH_HDR_BYTES = 14;
	localparam int unsigned ETH_IP_HDR_BYTES = 14 + 20;
	localparam int unsigned ICMP_SEQ_OFS = 6;

	localparam logic [1:0] KIND_IGNORED = 2'd0;
	localparam logic [1:0] KIND_LEARNED = 2'd1;
	localparam logic [1:0] KIND_ECHO    = 2'd2;
	localparam logic [1:0] KIND_HANDLED = 2'd3;

	typedef struct packed {
		logic             valid;
		logic             long_eth;
		logic             long_ip;
		logic [15:0]      ether_type;
		logic [15:0]      arp_opcode;
		logic [47:0]      sender_mac;
		logic [7:0]       ip_protocol;
		logic [7:0]       icmp_kind;
		logic [15:0]      echo_sequence;
		logic [LEN_W-1:0] frame_length;
	} frame_sum_t;

endpackage

@@ rtl/aic_if.sv @@
// ----------------------------------------------------------------------------
// ARP / ICMP reply classifier channels
// Valid/ready interfaces for frame bytes, results and the sequence register.
// ----------------------------------------------------------------------------
interface aic_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface aic_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_kind;
	logic        echo_matched;
	logic        gateway_known;
	logic [47:0] gateway_mac;
	logic [10:0] frame_length;

	modport source (output valid, output frame_kind, output echo_matched,
		output gateway_known, output gateway_mac, output frame_length, input ready);
	modport sink   (input valid, input frame_kind, input echo_matched,
		input gateway_known, input gateway_mac, input frame_length, output ready);
endinterface

interface aic_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] expected_seq;

	modport source (output valid, output expected_seq, input ready);
	modport sink   (input valid, input expected_seq, output ready);
endinterface

@@ rtl/aic_capture.sv @@
// ----------------------------------------------------------------------------
// ARP / ICMP reply classifier byte capture
// Registers each byte, tracks the offset and pulls header fields from the frame.
// ----------------------------------------------------------------------------
module aic_capture #(
	parameter int unsigned MAX_FRAME_BYTES = aic_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	aic_in_if.sink              rx,
	input  logic                out_free,
	output aic_pkg::frame_sum_t sum
);
	localparam int unsigned OW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [OW-1:0] MAX_OFF = OW'(MAX_FRAME_BYTES);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	logic [OW-1:0] offset_q;
	logic [15:0]   ether_type_q;
	logic [15:0]   arp_opcode_q;
	logic [47:0]   sender_mac_q;
	logic [7:0]    ip_protocol_q;
	logic [3:0]    header_words_q;
	logic [7:0]    icmp_kind_q;
	logic [15:0]   echo_seq_q;

	logic [OW-1:0] offset_n;
	logic [15:0]   ether_type_n;
	logic [15:0]   arp_opcode_n;
	logic [47:0]   sender_mac_n;
	logic [7:0]    ip_protocol_n;
	logic [3:0]    header_words_n;
	logic [7:0]    icmp_kind_n;
	logic [15:0]   echo_seq_n;

	logic          in_range;
	logic [6:0]    icmp_base;
	logic [6:0]    seq_hi_pos;
	logic          stall;
	logic          fire;
	logic [OW+aic_pkg::LEN_W-1:0] len_ext;

	// a last beat waits only when the result register is still occupied
	assign stall    = valid_s1 && last_s1 && !out_free;
	assign fire     = valid_s1 && !stall;
	assign rx.ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.frame_byte;
			last_s1 <= rx.last_byte;
		end
	end

	always_comb begin
		in_range       = offset_q < MAX_OFF;
		offset_n       = offset_q;
		ether_type_n   = ether_type_q;
		arp_opcode_n   = arp_opcode_q;
		sender_mac_n   = sender_mac_q;
		ip_protocol_n  = ip_protocol_q;
		header_words_n = header_words_q;
		icmp_kind_n    = icmp_kind_q;
		echo_seq_n     = echo_seq_q;
		if (in_range && offset_q == OW'(aic_pkg::POS_IHL)) begin
			header_words_n = byte_s1[3:0];
		end
		// icmp header follows the ip header, using the length just seen
		icmp_base  = 7'(aic_pkg::ETH_HDR_BYTES) + {1'b0, header_words_n, 2'b00};
		seq_hi_pos = icmp_base + 7'(aic_pkg::ICMP_SEQ_OFS);
		if (in_range) begin
			offset_n = offset_q + OW'(1);
			if (offset_q == OW'(aic_pkg::POS_ETYPE_HI) ||
				offset_q == OW'(aic_pkg::POS_ETYPE_LO)) begin
				ether_type_n = {ether_type_q[7:0], byte_s1};
			end
			if (offset_q == OW'(aic_pkg::POS_OPCODE_HI) ||
				offset_q == OW'(aic_pkg::POS_OPCODE_LO)) begin
				arp_opcode_n = {arp_opcode_q[7:0], byte_s1};
			end
			if (offset_q >= OW'(aic_pkg::POS_SMAC_FIRST) &&
				offset_q <= OW'(aic_pkg::POS_SMAC_LAST)) begin
				sender_mac_n = {sender_mac_q[39:0], byte_s1};
			end
			if (offset_q == OW'(aic_pkg::POS_IP_PROTO)) begin
				ip_protocol_n = byte_s1;
			end
			if (offset_q == OW'(icmp_base)) begin
				icmp_kind_n = byte_s1;
			end
			if (offset_q == OW'(seq_hi_pos) || offset_q == OW'(seq_hi_pos + 7'd1)) begin
				echo_seq_n = {echo_seq_q[7:0], byte_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q       <= '0;
			ether_type_q   <= '0;
			arp_opcode_q   <= '0;
			sender_mac_q   <= '0;
			ip_protocol_q  <= '0;
			header_words_q <= '0;
			icmp_kind_q    <= '0;
			echo_seq_q     <= '0;
		end else if (fire) begin
			if (last_s1) begin
				offset_q       <= '0;
				ether_type_q   <= '0;
				arp_opcode_q   <= '0;
				sender_mac_q   <= '0;
				ip_protocol_q  <= '0;
				header_words_q <= '0;
				icmp_kind_q    <= '0;
				echo_seq_q     <= '0;
			end else begin
				offset_q       <= offset_n;
				ether_type_q   <= ether_type_n;
				arp_opcode_q   <= arp_opcode_n;
				sender_mac_q   <= sender_mac_n;
				ip_protocol_q  <= ip_protocol_n;
				header_words_q <= header_words_n;
				icmp_kind_q    <= icmp_kind_n;
				echo_seq_q     <= echo_seq_n;
			end
		end
	end

	assign len_ext = {{aic_pkg::LEN_W{1'b0}}, offset_n};

	always_comb begin
		sum.valid         = fire && last_s1;
		sum.long_eth      = offset_n > OW'(aic_pkg::ETH_HDR_BYTES);
		sum.long_ip       = offset_n > OW'(aic_pkg::ETH_IP_HDR_BYTES);
		sum.ether_type    = ether_type_n;
		sum.arp_opcode    = arp_opcode_n;
		sum.sender_mac    = sender_mac_n;
		sum.ip_protocol   = ip_protocol_n;
		sum.icmp_kind     = icmp_kind_n;
		sum.echo_sequence = echo_seq_n;
		sum.frame_length  = len_ext[aic_pkg::LEN_W-1:0];
	end

endmodule

@@ rtl/aic_classify.sv @@
// ----------------------------------------------------------------------------
// ARP / ICMP reply classifier decision stage
// Classifies a finished frame, keeps the gateway MAC and holds the result beat.
// ----------------------------------------------------------------------------
module aic_classify (
	input  logic                clk,
	input  logic                arst_n,
	input  aic_pkg::frame_sum_t sum,
	input  logic [15:0]         expected_seq,
	aic_out_if.source           tx,
	output logic                out_free
);
	logic        mac_learned_q;
	logic [47:0] learned_mac_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic        matched_q;
	logic        known_q;
	logic [47:0] mac_q;
	logic [10:0] len_q;

	logic [1:0]  kind;
	logic        matched;
	logic        learn;
	logic        is_arp;

	assign out_free = !out_valid_q || tx.ready;

	always_comb begin
		kind    = aic_pkg::KIND_IGNORED;
		matched = 1'b0;
		learn   = 1'b0;
		is_arp  = 1'b0;
		if (!mac_learned_q) begin
			// no gateway yet: only arp frames are looked at
			is_arp = sum.long_eth && sum.ether_type == aic_pkg::ETYPE_ARP;
		end else if (sum.long_ip) begin
			if (sum.ether_type == aic_pkg::ETYPE_IPV4) begin
				if (sum.ip_protocol == aic_pkg::IP_PROTO_ICMP &&
					sum.icmp_kind == aic_pkg::ICMP_ECHO_REPLY &&
					sum.echo_sequence == expected_seq) begin
					kind    = aic_pkg::KIND_ECHO;
					matched = 1'b1;
				end else begin
					kind = aic_pkg::KIND_HANDLED;
				end
			end else begin
				is_arp = sum.ether_type == aic_pkg::ETYPE_ARP;
			end
		end
		if (is_arp) begin
			if (sum.arp_opcode == aic_pkg::ARP_OP_REPLY) begin
				kind  = aic_pkg::KIND_LEARNED;
				learn = 1'b1;
			end else begin
				kind = aic_pkg::KIND_HANDLED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_learned_q <= 1'b0;
			learned_mac_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (sum.valid && learn) begin
				mac_learned_q <= 1'b1;
				learned_mac_q <= sum.sender_mac;
			end
			if (sum.valid) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum.valid) begin
			kind_q    <= kind;
			matched_q <= matched;
			known_q   <= mac_learned_q | learn;
			mac_q     <= learn ? sum.sender_mac : learned_mac_q;
			len_q     <= sum.frame_length;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.frame_kind    = kind_q;
	assign tx.echo_matched  = matched_q;
	assign tx.gateway_known = known_q;
	assign tx.gateway_mac   = mac_q;
	assign tx.frame_length  = len_q;

endmodule

@@ rtl/arp_icmp_reply_classifier_core.sv @@
// ----------------------------------------------------------------------------
// ARP / ICMP reply classifier
// Learns the gateway MAC from ARP replies and flags matching ICMP echo replies.
// ----------------------------------------------------------------------------
// result path: last byte -> byte register -> result register -> result beat
// throughput: one byte per cycle; a last byte stalls only while a result beat waits
// reset (arst_n low): offset, captures, gateway MAC and expected sequence go to zero
`include "arp_icmp_reply_classifier_core_macros.svh"

module arp_icmp_reply_classifier_core #(
	parameter int unsigned MAX_FRAME_BYTES = aic_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	aic_in_if.sink     rx,
	aic_out_if.source  tx,
	aic_cfg_if.sink    cfg
);
	logic [15:0]         expected_seq_q;
	aic_pkg::frame_sum_t sum;
	logic                out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q <= '0;
		end else if (cfg.valid) begin
			expected_seq_q <= cfg.expected_seq;
		end
	end

	aic_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.out_free (out_free),
		.sum      (sum)
	);

	aic_classify u_classify (
		.clk          (clk),
		.arst_n       (arst_n),
		.sum          (sum),
		.expected_seq (expected_seq_q),
		.tx           (tx),
		.out_free     (out_free)
	);

	// byte side only backs up behind an unread result beat
	`AIC_ASSERT_SAME(a_stall_cause, clk, arst_n, !rx.ready, tx.valid && !tx.ready)
	`AIC_ASSERT_SAME(a_match_kind, clk, arst_n, tx.valid,
		tx.echo_matched == (tx.frame_kind == aic_pkg::KIND_ECHO))
	`AIC_ASSERT_SAME(a_learn_known, clk, arst_n,
		tx.valid && tx.frame_kind == aic_pkg::KIND_LEARNED, tx.gateway_known)

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP / ICMP reply classifier testbench
// Streams Ethernet frames byte by byte into the classifier, predicts the
// per-frame verdict, gateway state and length, and checks every result beat
// under random idling, a long receiver hold-off and several sequence settings.
// ----------------------------------------------------------------------------
module testbench;
	import aic_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 4;

	localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [7:0] IP_PROTO_TCP = 8'h06;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'h08;

	typedef struct packed {
		logic [1:0]       kind;
		logic             matched;
		logic             known;
		logic [47:0]      mac;
		logic [LEN_W-1:0] length;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	aic_in_if  rx_ch ();
	aic_out_if tx_ch ();
	aic_cfg_if cfg_ch ();

	arp_icmp_reply_classifier_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted state of the classifier
	int unsigned rx_pos;
	logic [15:0] cap_etype;
	logic [15:0] cap_opcode;
	logic [47:0] cap_smac;
	logic [7:0]  cap_proto;
	logic [3:0]  cap_words;
	logic [7:0]  cap_icmp_type;
	logic [15:0] cap_seq;
	logic [47:0] gw_mac;
	logic        gw_known;
	logic [15:0] seq_setting;

	verdict_t    expected_verdicts[$];
	logic [7:0]  frame_buf[$];
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned phase_bytes;
	int unsigned stall_left;
	logic        tx_idle_on;
	logic        rx_idle_on;
	logic        hold_start;
	logic        hold_active;

	function automatic logic [1:0] arp_outcome();
		if (cap_opcode == ARP_OP_REPLY) begin
			gw_mac = cap_smac;
			gw_known = 1'b1;
			return KIND_LEARNED;
		end
		return KIND_HANDLED;
	endfunction

	// advance the prediction by one accepted byte; a last byte yields a verdict
	task automatic classify_byte(input logic [7:0] b, input logic last);
		int unsigned base;
		verdict_t v;
		if (rx_pos < MAX_FRAME_BYTES_DEF) begin
			if (rx_pos == POS_ETYPE_HI || rx_pos == POS_ETYPE_LO)
				cap_etype = {cap_etype[7:0], b};
			if (rx_pos == POS_IHL)
				cap_words = b[3:0];
			if (rx_pos == POS_OPCODE_HI || rx_pos == POS_OPCODE_LO)
				cap_opcode = {cap_opcode[7:0], b};
			if (rx_pos >= POS_SMAC_FIRST && rx_pos <= POS_SMAC_LAST)
				cap_smac = {cap_smac[39:0], b};
			if (rx_pos == POS_IP_PROTO)
				cap_proto = b;
			// icmp header follows the ip header as its length field says, even if bogus
			base = ETH_HDR_BYTES + 4 * cap_words;
			if (rx_pos == base)
				cap_icmp_type = b;
			if (rx_pos == base + ICMP_SEQ_OFS || rx_pos == base + ICMP_SEQ_OFS + 1)
				cap_seq = {cap_seq[7:0], b};
			rx_pos++;
		end
		if (last) begin
			v = '0;
			v.kind = KIND_IGNORED;
			if (!gw_known) begin
				if (rx_pos > ETH_HDR_BYTES && cap_etype == ETYPE_ARP)
					v.kind = arp_outcome();
			end else if (rx_pos > ETH_IP_HDR_BYTES) begin
				if (cap_etype == ETYPE_IPV4) begin
					if (cap_proto == IP_PROTO_ICMP && cap_icmp_type == ICMP_ECHO_REPLY &&
							cap_seq == seq_setting) begin
						v.kind = KIND_ECHO;
						v.matched = 1'b1;
					end else begin
						v.kind = KIND_HANDLED;
					end
				end else if (cap_etype == ETYPE_ARP) begin
					v.kind = arp_outcome();
				end
			end
			v.known = gw_known;
			v.mac = gw_mac;
			v.length = rx_pos[LEN_W-1:0];
			expected_verdicts.push_back(v);
			rx_pos = 0;
			cap_etype = '0;
			cap_opcode = '0;
			cap_smac = '0;
			cap_proto = '0;
			cap_words = '0;
			cap_icmp_type = '0;
			cap_seq = '0;
		end
	endtask

	// ---- frame construction ----

	function automatic void fill_noise(int unsigned len);
		frame_buf.delete();
		repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void poke(int unsigned at, logic [7:0] value);
		if (at < frame_buf.size())
			frame_buf[at] = value;
	endfunction

	function automatic void build_arp(int unsigned len, logic [15:0] op, logic [47:0] mac);
		fill_noise(len);
		poke(POS_ETYPE_HI, ETYPE_ARP[15:8]);
		poke(POS_ETYPE_LO, ETYPE_ARP[7:0]);
		poke(POS_OPCODE_HI, op[15:8]);
		poke(POS_OPCODE_LO, op[7:0]);
		for (int i = 0; i < 6; i++)
			poke(POS_SMAC_FIRST + i, mac[47 - 8 * i -: 8]);
	endfunction

	function automatic void build_ipv4(int unsigned len, logic [3:0] words, logic [7:0] proto,
			logic [7:0] icmp_type, logic [15:0] seq);
		int unsigned base;
		base = ETH_HDR_BYTES + 4 * words;
		fill_noise(len);
		poke(POS_ETYPE_HI, ETYPE_IPV4[15:8]);
		poke(POS_ETYPE_LO, ETYPE_IPV4[7:0]);
		poke(POS_IHL, {4'h4, words});
		poke(POS_IP_PROTO, proto);
		poke(base, icmp_type);
		poke(base + ICMP_SEQ_OFS, seq[15:8]);
		poke(base + ICMP_SEQ_OFS + 1, seq[7:0]);
	endfunction

	// mostly well-formed arp and echo traffic, with near misses, short frames and noise
	function automatic void pick_random_frame();
		int unsigned sel;
		int unsigned words;
		int unsigned len;
		sel = $urandom_range(0, 99);
		words = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
		if ($urandom_range(0, 7) == 0)
			len = $urandom_range(1, 40);
		else
			len = ETH_HDR_BYTES + 4 * words + 8 + $urandom_range(0, 24);
		if (sel < 15) begin
			build_arp(len, ARP_OP_REPLY, 48'({$urandom, $urandom}));
		end else if (sel < 25) begin
			build_arp(len, $urandom_range(0, 1) ? ARP_OP_REQUEST : 16'($urandom),
				48'({$urandom, $urandom}));
		end else if (sel < 55) begin
			build_ipv4(len, 4'(words), IP_PROTO_ICMP, ICMP_ECHO_REPLY, seq_setting);
		end else if (sel < 75) begin
			case ($urandom_range(0, 2))
				0: build_ipv4(len, 4'(words), IP_PROTO_ICMP, ICMP_ECHO_REPLY,
					seq_setting ^ 16'($urandom_range(1, 65535)));
				1: build_ipv4(len, 4'(words), IP_PROTO_ICMP,
					$urandom_range(0, 1) ? ICMP_ECHO_REQUEST : 8'($urandom_range(1, 255)),
					seq_setting);
				default: build_ipv4(len, 4'(words), 8'($urandom_range(2, 255)),
					ICMP_ECHO_REPLY, seq_setting);
			endcase
		end else if (sel < 85) begin
			build_ipv4(len, 4'(words), 8'($urandom), 8'($urandom), 16'($urandom));
		end else begin
			fill_noise($urandom_range(1, 80));
		end
	endfunction

	// ---- drivers ----

	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = (tx_idle_on && $urandom_range(0, 1)) ? $urandom_range(0, 13) : 0;
		@(negedge clk);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.frame_byte <= b;
		rx_ch.last_byte <= last;
		do @(posedge clk); while (!rx_ch.ready);
		classify_byte(b, last);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		phase_bytes += frame_buf.size();
	endtask

	// stop offering bytes and wait until every predicted verdict has come back
	task automatic settle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_expected_seq(input logic [15:0] value);
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.expected_seq <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		seq_setting = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ---- result side ----

	initial begin
		hold_active = 1'b0;
		forever begin
			wait (hold_start);
			@(posedge clk);
			hold_start = 1'b0;
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				tx_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				tx_ch.ready <= !hold_active;
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			got = {tx_ch.frame_kind, tx_ch.echo_matched, tx_ch.gateway_known,
				tx_ch.gateway_mac, tx_ch.frame_length};
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: kind %0d len %0d", got.kind, got.length);
			end else begin
				want = expected_verdicts.pop_front();
				if (got.kind !== want.kind || got.matched !== want.matched ||
						got.known !== want.known || got.mac !== want.mac ||
						got.length !== want.length) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch (expected/actual): kind %0d/%0d matched %0b/%0b",
							want.kind, got.kind, want.matched, got.matched);
						$display("  known %0b/%0b mac %012h/%012h len %0d/%0d",
							want.known, got.known, want.mac, got.mac,
							want.length, got.length);
					end
				end
			end
			stall_left = rx_idle_on ? $urandom_range(0, 13) : 0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---- tests ----

	task automatic test_gateway_learning();
		fill_noise(1);
		send_frame();
		build_arp(14, ARP_OP_REPLY, 48'h0123_4567_89AB);
		send_frame();
		// ip traffic is dropped until a gateway is known
		build_ipv4(42, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, seq_setting);
		send_frame();
		build_arp(42, ARP_OP_REQUEST, 48'h0A0B_0C0D_0E0F);
		send_frame();
		build_arp(15, ARP_OP_REPLY, 48'h1111_2222_3333);
		send_frame();
		// truncated reply: no gateway is known yet, so it is learned from a partial sender MAC
		build_arp(24, ARP_OP_REPLY, 48'hDEAD_BEEF_CAFE);
		send_frame();
		build_arp(34, ARP_OP_REPLY, 48'h5555_5555_5555);
		send_frame();
		build_arp(42, ARP_OP_REPLY, 48'hFFFF_FFFF_FFFF);
		send_frame();
		build_arp(60, ARP_OP_REPLY, 48'h0000_0000_0000);
		send_frame();
		build_arp(42, ARP_OP_REPLY, 48'({$urandom, $urandom}));
		send_frame();
	endtask

	task automatic test_echo_match();
		write_expected_seq(16'hFFFF);
		build_ipv4(42, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'hFFFF);
		send_frame();
		build_ipv4(42, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'hFFFE);
		send_frame();
		build_ipv4(42, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REQUEST, 16'hFFFF);
		send_frame();
		build_ipv4(42, 4'd5, IP_PROTO_TCP, ICMP_ECHO_REPLY, 16'hFFFF);
		send_frame();
		build_ipv4(34, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'hFFFF);
		send_frame();
		build_ipv4(35, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'hFFFF);
		send_frame();
		write_expected_seq(16'h0000);
		// sequence bytes never arrive, so they count as zero and match
		build_ipv4(35, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'h0000);
		send_frame();
		// icmp header overlapping the ip header
		build_ipv4(36, 4'd0, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'h0000);
		send_frame();
		build_ipv4(40, 4'd1, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'h0000);
		send_frame();
		build_ipv4(40, 4'd2, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'h0000);
		send_frame();
		build_ipv4(82, 4'd15, IP_PROTO_ICMP, ICMP_ECHO_REPLY, 16'h0000);
		send_frame();
		build_arp(60, ETYPE_IPV6, 48'h0);
		poke(POS_ETYPE_HI, ETYPE_IPV6[15:8]);
		poke(POS_ETYPE_LO, ETYPE_IPV6[7:0]);
		send_frame();
	endtask

	task automatic test_long_frames();
		build_ipv4(MAX_FRAME_BYTES_DEF, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, seq_setting);
		send_frame();
		fill_noise(MAX_FRAME_BYTES_DEF + 5);
		send_frame();
	endtask

	task automatic test_backpressure();
		settle();
		hold_start = 1'b1;
		// keep offering frames while the result side is held off
		repeat (8) begin
			build_ipv4(40, 4'd5, IP_PROTO_ICMP, ICMP_ECHO_REPLY, seq_setting);
			send_frame();
		end
		settle();
		repeat (4) begin
			pick_random_frame();
			send_frame();
		end
	endtask

	task automatic test_random_traffic();
		logic [15:0] value;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0)
				value = 16'h0000;
			else if (ph == 1)
				value = 16'hFFFF;
			else
				value = 16'($urandom_range(0, 65535));
			write_expected_seq(value);
			tx_idle_on = ph[0];
			rx_idle_on = ph[1];
			phase_bytes = 0;
			while (phase_bytes < 200) begin
				pick_random_frame();
				send_frame();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.frame_byte = '0;
		rx_ch.last_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.expected_seq = '0;
		tx_ch.ready = 1'b0;
		rx_pos = 0;
		cap_etype = '0;
		cap_opcode = '0;
		cap_smac = '0;
		cap_proto = '0;
		cap_words = '0;
		cap_icmp_type = '0;
		cap_seq = '0;
		gw_mac = '0;
		gw_known = 1'b0;
		seq_setting = '0;
		mismatches = 0;
		cycle_count = 0;
		phase_bytes = 0;
		stall_left = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_start = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_gateway_learning();
		test_echo_match();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_long_frames();
		test_backpressure();
		test_random_traffic();
		settle();

		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
